// File: design/lab2rgb_pkg.sv
// ----------------------------------------------------------------------------
// lab2rgb_pkg
// Shared types and fixed-point constants for the CIELAB to RGB byte pipeline.
// All internal values are signed Q.24; reciprocal constants are exact for the
// operand ranges that reach them.
// ----------------------------------------------------------------------------
package lab2rgb_pkg;

  localparam int FRAC_BITS = 24;

  typedef logic signed [26:0] fval_t;   // f values, Q.24
  typedef logic signed [28:0] tval_t;   // inverse-companded values, Q.24
  typedef logic signed [29:0] xyz_t;    // XYZ after white scaling, Q.24
  typedef logic signed [26:0] coef_t;   // matrix coefficients, Q.24
  typedef logic signed [25:0] white_t;  // white point scale, Q.24

  typedef fval_t fvec_t [3];
  typedef tval_t tvec_t [3];

  localparam logic [63:0] ONE64 = 64'd1;

  // fx = floor((L + 4096) * 2^14 / 29), numerator below 2^30
  localparam logic [15:0] L_OFFSET = 16'd4096;
  localparam int          L_SHIFT  = 21;
  localparam logic [30:0] L_RECIP  = 31'(((ONE64 << 35) + 64'd28) / 64'd29);

  // a / 500: floor((a * 2^14 + 125 * 2^23) / 125) - 2^23, numerator below 2^31
  localparam int          A_SHIFT  = 38;
  localparam logic [31:0] A_RECIP  = 32'(((ONE64 << 38) + 64'd124) / 64'd125);
  localparam logic [30:0] A_BIAS   = 31'd1048576000;
  localparam logic signed [27:0] A_BIAS_Q = 28'sd8388608;

  // b / 200: floor((b * 2^13 + 25 * 2^24) / 25) - 2^24, numerator below 2^30
  localparam int          B_SHIFT  = 35;
  localparam logic [30:0] B_RECIP  = 31'(((ONE64 << 35) + 64'd24) / 64'd25);
  localparam logic [29:0] B_BIAS   = 30'd419430400;
  localparam logic signed [27:0] B_BIAS_Q = 28'sd16777216;

  // inverse companding
  localparam fval_t F_THR = 27'sd3471148;   // 6/29
  localparam fval_t F4_29 = 27'sd2314099;   // 16/116
  // linear segment: floor((e + 7787 * 2048) * 1000 / 7787) - 2048000
  localparam logic signed [27:0] LIN_BIAS   = 28'sd15947776;
  localparam logic signed [28:0] LIN_BIAS_Q = 29'sd2048000;
  localparam int          LIN_SHIFT  = 38;
  localparam logic [35:0] LIN_RECIP  =
    36'(((64'd1000 << 38) + 64'd7786) / 64'd7787);
  localparam int          LIN_SPLIT  = 18;
  localparam logic [17:0] LIN_RECIP_HI = LIN_RECIP[35:18];
  localparam logic [17:0] LIN_RECIP_LO = LIN_RECIP[17:0];

  // D65 white
  localparam white_t WHITE_X = 26'sd15945066;
  localparam white_t WHITE_Z = 26'sd18267033;

  // XYZ to linear RGB
  localparam coef_t XYZ2RGB [3][3] = '{
    '{ 27'sd54366256, -27'sd25789124, -27'sd8364051},
    '{-27'sd16261400,  27'sd31473889,  27'sd697192},
    '{ 27'sd933595,   -27'sd3423245,   27'sd17738737}
  };

  localparam logic [24:0] CH_ONE = 25'd16777216;

endpackage

// File: design/lab2rgb_fval.sv
// ----------------------------------------------------------------------------
// lab2rgb_fval
// Two-stage front end: reciprocal multiplies for L, a and b, then the f sums.
// ----------------------------------------------------------------------------
module lab2rgb_fval import lab2rgb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [14:0]        lightness,
  input  logic signed [15:0] green_red_axis,
  input  logic signed [15:0] blue_yellow_axis,
  output logic               out_valid,
  input  logic               out_ready,
  output fvec_t              f
);

  logic s1_vld_r, s2_vld_r;
  logic s1_rdy, s2_rdy;

  assign s2_rdy    = !s2_vld_r || out_ready;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_ready  = s1_rdy;
  assign out_valid = s2_vld_r;

  // stage 1: quotients
  logic [15:0] l_ofs;
  logic [46:0] l_prod;
  logic [30:0] a_num;
  logic [62:0] a_prod;
  logic [29:0] b_num;
  logic [60:0] b_prod;
  logic [24:0] qx_nxt, qa_nxt, qx_r, qa_r;
  logic [25:0] qb_nxt, qb_r;

  assign l_ofs  = {1'b0, lightness} + L_OFFSET;
  assign l_prod = l_ofs * L_RECIP;
  assign qx_nxt = l_prod[L_SHIFT+24:L_SHIFT];

  assign a_num  = A_BIAS + {green_red_axis[15], green_red_axis, 14'b0};
  assign a_prod = a_num * A_RECIP;
  assign qa_nxt = a_prod[A_SHIFT+24:A_SHIFT];

  assign b_num  = B_BIAS + {blue_yellow_axis[15], blue_yellow_axis, 13'b0};
  assign b_prod = b_num * B_RECIP;
  assign qb_nxt = b_prod[B_SHIFT+25:B_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      qx_r <= qx_nxt;
      qa_r <= qa_nxt;
      qb_r <= qb_nxt;
    end
  end

  // stage 2: fy = fx - a/500, fz = fy - b/200
  logic signed [27:0] fx_s, fy_s, fz_s;
  fvec_t f_nxt, f_r;

  always_comb begin
    fx_s     = signed'({3'b0, qx_r});
    fy_s     = fx_s - (signed'({3'b0, qa_r}) - A_BIAS_Q);
    fz_s     = fy_s - (signed'({2'b0, qb_r}) - B_BIAS_Q);
    f_nxt[0] = fx_s[26:0];
    f_nxt[1] = fy_s[26:0];
    f_nxt[2] = fz_s[26:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      f_r <= f_nxt;
    end
  end

  assign f = f_r;

endmodule

// File: design/lab2rgb_compand.sv
// ----------------------------------------------------------------------------
// lab2rgb_compand
// Three-lane inverse companding, two stages: cube and linear segment run side
// by side, the threshold picks one at the end.
// ----------------------------------------------------------------------------
module lab2rgb_compand import lab2rgb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  fvec_t f,
  output logic  out_valid,
  input  logic  out_ready,
  output tvec_t t
);

  logic sa_vld_r, sb_vld_r;
  logic sa_rdy, sb_rdy;

  assign sb_rdy    = !sb_vld_r || out_ready;
  assign sa_rdy    = !sa_vld_r || sb_rdy;
  assign in_ready  = sa_rdy;
  assign out_valid = sb_vld_r;

  // stage A: square and split linear product
  logic               sel_nxt [3];
  logic [25:0]        fu_nxt  [3];
  logic [51:0]        sq_prod [3];
  logic [27:0]        sq_nxt  [3];
  logic signed [27:0] e_full  [3];
  logic [24:0]        e_u     [3];
  logic [42:0]        ph_nxt  [3];
  logic [42:0]        pl_nxt  [3];

  logic               sel_r [3];
  logic [25:0]        fu_r  [3];
  logic [27:0]        sq_r  [3];
  logic [42:0]        ph_r  [3];
  logic [42:0]        pl_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel_nxt[i] = f[i] > F_THR;
      fu_nxt[i]  = f[i][25:0];
      sq_prod[i] = fu_nxt[i] * fu_nxt[i];
      sq_nxt[i]  = sq_prod[i][FRAC_BITS+27:FRAC_BITS];
      e_full[i]  = 28'(f[i]) - 28'(F4_29) + LIN_BIAS;
      e_u[i]     = e_full[i][24:0];
      ph_nxt[i]  = e_u[i] * LIN_RECIP_HI;
      pl_nxt[i]  = e_u[i] * LIN_RECIP_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (sa_rdy) begin
      sa_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sa_rdy) begin
      sel_r <= sel_nxt;
      fu_r  <= fu_nxt;
      sq_r  <= sq_nxt;
      ph_r  <= ph_nxt;
      pl_r  <= pl_nxt;
    end
  end

  // stage B: finish cube, recombine linear quotient, select
  logic [53:0] cube [3];
  logic [27:0] tc   [3];
  logic [61:0] lsum [3];
  logic [23:0] lq   [3];
  tval_t       tl   [3];
  tvec_t       t_nxt, t_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cube[i]  = sq_r[i] * fu_r[i];
      tc[i]    = cube[i][FRAC_BITS+27:FRAC_BITS];
      lsum[i]  = {ph_r[i], {LIN_SPLIT{1'b0}}, 1'b0} >> 1;
      lsum[i]  = lsum[i] + 62'(pl_r[i]);
      lq[i]    = lsum[i][LIN_SHIFT+23:LIN_SHIFT];
      tl[i]    = signed'({5'b0, lq[i]}) - LIN_BIAS_Q;
      t_nxt[i] = sel_r[i] ? signed'({1'b0, tc[i]}) : tl[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
    end else if (sb_rdy) begin
      sb_vld_r <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sb_rdy) begin
      t_r <= t_nxt;
    end
  end

  assign t = t_r;

endmodule

// File: design/lab2rgb_mix.sv
// ----------------------------------------------------------------------------
// lab2rgb_mix
// Four-stage back end: white scaling, matrix products, sum and clamp, byte
// scaling into the output register.
// ----------------------------------------------------------------------------
module lab2rgb_mix import lab2rgb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tvec_t      t,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic sw_vld_r, sp_vld_r, sc_vld_r, so_vld_r;
  logic sw_rdy, sp_rdy, sc_rdy, so_rdy;

  assign so_rdy    = !so_vld_r || out_ready;
  assign sc_rdy    = !sc_vld_r || so_rdy;
  assign sp_rdy    = !sp_vld_r || sc_rdy;
  assign sw_rdy    = !sw_vld_r || sp_rdy;
  assign in_ready  = sw_rdy;
  assign out_valid = so_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_vld_r <= 1'b0;
      sp_vld_r <= 1'b0;
      sc_vld_r <= 1'b0;
      so_vld_r <= 1'b0;
    end else begin
      if (sw_rdy) sw_vld_r <= in_valid;
      if (sp_rdy) sp_vld_r <= sw_vld_r;
      if (sc_rdy) sc_vld_r <= sp_vld_r;
      if (so_rdy) so_vld_r <= sc_vld_r;
    end
  end

  // white scaling
  logic signed [54:0] x_prod, z_prod;
  xyz_t xyz_nxt [3];
  xyz_t xyz_r   [3];

  always_comb begin
    x_prod     = t[0] * WHITE_X;
    z_prod     = t[2] * WHITE_Z;
    xyz_nxt[0] = x_prod[FRAC_BITS+29:FRAC_BITS];
    xyz_nxt[1] = 30'(t[1]);
    xyz_nxt[2] = z_prod[FRAC_BITS+29:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (sw_rdy) begin
      xyz_r <= xyz_nxt;
    end
  end

  // matrix products
  logic signed [56:0] prod_nxt [3][3];
  logic signed [56:0] prod_r   [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = xyz_r[c] * XYZ2RGB[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sp_rdy) begin
      prod_r <= prod_nxt;
    end
  end

  // sum, floor to Q.24 and clamp to [0, 1]
  logic signed [58:0] sum  [3];
  logic [24:0]        ch_nxt [3];
  logic [24:0]        ch_r   [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 59'(prod_r[r][0]) + 59'(prod_r[r][1]) + 59'(prod_r[r][2]);
      if (sum[r][58]) begin
        ch_nxt[r] = '0;
      end else if (sum[r][57:FRAC_BITS] > 34'(CH_ONE)) begin
        ch_nxt[r] = CH_ONE;
      end else begin
        ch_nxt[r] = sum[r][FRAC_BITS+24:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sc_rdy) begin
      ch_r <= ch_nxt;
    end
  end

  // byte = floor(255 * ch / 2^24)
  logic [32:0] scaled [3];
  logic [7:0]  byte_nxt [3];
  logic [7:0]  byte_r   [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      scaled[r]   = {ch_r[r], 8'b0} - 33'(ch_r[r]);
      byte_nxt[r] = scaled[r][FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (so_rdy) begin
      byte_r <= byte_nxt;
    end
  end

  assign red   = byte_r[0];
  assign green = byte_r[1];
  assign blue  = byte_r[2];

endmodule

// File: design/cielab_to_rgb_bytes.sv
// ----------------------------------------------------------------------------
// cielab_to_rgb_bytes
// CIELAB (D65) to 8-bit linear RGB, fully pipelined, one beat per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Each input beat carries L (unsigned Q7.8) and a, b (signed Q8.8) and yields
// exactly one output beat of red, green and blue bytes, in order. The datapath
// is eight register stages deep: two for the f values (reciprocal multiplies,
// then sums), two for inverse companding (square or split linear product,
// then cube or recombine), and four for white scaling, matrix products,
// sum with clamp, and byte scaling into the output register. Every stage holds
// one beat and carries its own valid bit, so a new beat is taken on every
// clock unless the output is stalled with all stages full. A stage holds
// only when it is full and the stage after it is holding, so bubbles are
// squeezed out under backpressure and in_ready drops only when all eight
// stages are full and the output is stalled. No gamma is applied; channels
// outside the gamut saturate to 0 or 255.
// ----------------------------------------------------------------------------
module cielab_to_rgb_bytes import lab2rgb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [14:0]        in_lightness,
  input  logic signed [15:0] in_green_red_axis,
  input  logic signed [15:0] in_blue_yellow_axis,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam logic [3:0] PIPE_DEPTH = 4'd8;

  // front end to companding
  logic  fv_valid, fv_ready;
  fvec_t fv;

  // companding to mixing
  logic  tv_valid, tv_ready;
  tvec_t tv;

  lab2rgb_fval u_fval (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .lightness        (in_lightness),
    .green_red_axis   (in_green_red_axis),
    .blue_yellow_axis (in_blue_yellow_axis),
    .out_valid        (fv_valid),
    .out_ready        (fv_ready),
    .f                (fv)
  );

  lab2rgb_compand u_compand (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv_valid),
    .in_ready  (fv_ready),
    .f         (fv),
    .out_valid (tv_valid),
    .out_ready (tv_ready),
    .t         (tv)
  );

  lab2rgb_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tv_valid),
    .in_ready  (tv_ready),
    .t         (tv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

  // Track beats in flight to check the pipeline never drops or invents one.
  logic       in_beat, out_beat;
  logic [3:0] inflight_r, inflight_nxt;

  assign in_beat      = in_valid && in_ready;
  assign out_beat     = out_valid && out_ready;
  assign inflight_nxt = inflight_r + {3'b0, in_beat} - {3'b0, out_beat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= PIPE_DEPTH)
    else $error("more beats in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 4'd0)
    else $error("output beat with no input beat in flight");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input held while output is not stalled");

endmodule
